### hw/rtl/pmd_pkg.sv
// ----------------------------------------------------------------------------
// pmd_pkg
// Shared constants, controller states and the command and status bundles
// for the dense minimum spanning tree block.
// ----------------------------------------------------------------------------
package pmd_pkg;

  localparam int MAX_VERTICES_DEF = 32;
  localparam int WEIGHT_BITS_DEF  = 16;
  localparam int VERT_W           = 6;
  localparam int CFG_W            = 6;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LD_READ,
    ST_LD_WR1,
    ST_LD_WR2,
    ST_INIT,
    ST_SWEEP,
    ST_SWEEP_DRAIN,
    ST_ROUND_END,
    ST_EMIT,
    ST_EMIT_DRAIN
  } state_t;

  typedef struct packed {
    logic accept;
    logic ld_wr1;
    logic ld_wr2;
    logic prim_init;
    logic scan_issue;
    logic emit_issue;
    logic next_round;
    logic emit_start;
    logic clear_start;
    logic clear_step;
  } cmd_t;

  typedef struct packed {
    logic n_one;
    logic scan_last;
    logic found;
    logic rnd_last;
    logic clr_last;
  } sts_t;

endpackage

### hw/rtl/pmd_ctrl.sv
// ----------------------------------------------------------------------------
// pmd_ctrl
// Sequencer: edge load, prim sweeps, result emission and store clearing.
// ----------------------------------------------------------------------------
module pmd_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  input  logic           in_last_edge,
  input  pmd_pkg::sts_t  sts,
  output logic           busy,
  output pmd_pkg::cmd_t  cmd
);

  pmd_pkg::state_t st_r;
  pmd_pkg::state_t st_nxt;
  logic            last_r;
  logic            last_nxt;

  always_comb begin
    st_nxt   = st_r;
    last_nxt = last_r;
    case (st_r)
      pmd_pkg::ST_CLEAR: begin
        if (sts.clr_last) st_nxt = pmd_pkg::ST_IDLE;
      end
      pmd_pkg::ST_IDLE: begin
        if (start) begin
          st_nxt   = pmd_pkg::ST_LD_READ;
          last_nxt = in_last_edge;
        end
      end
      pmd_pkg::ST_LD_READ: st_nxt = pmd_pkg::ST_LD_WR1;
      pmd_pkg::ST_LD_WR1:  st_nxt = pmd_pkg::ST_LD_WR2;
      pmd_pkg::ST_LD_WR2: begin
        st_nxt = last_r ? pmd_pkg::ST_INIT : pmd_pkg::ST_IDLE;
      end
      pmd_pkg::ST_INIT: begin
        st_nxt = sts.n_one ? pmd_pkg::ST_CLEAR : pmd_pkg::ST_SWEEP;
      end
      pmd_pkg::ST_SWEEP: begin
        if (sts.scan_last) st_nxt = pmd_pkg::ST_SWEEP_DRAIN;
      end
      pmd_pkg::ST_SWEEP_DRAIN: st_nxt = pmd_pkg::ST_ROUND_END;
      pmd_pkg::ST_ROUND_END: begin
        st_nxt = (sts.found && !sts.rnd_last) ? pmd_pkg::ST_SWEEP : pmd_pkg::ST_EMIT;
      end
      pmd_pkg::ST_EMIT: begin
        if (sts.scan_last) st_nxt = pmd_pkg::ST_EMIT_DRAIN;
      end
      pmd_pkg::ST_EMIT_DRAIN: st_nxt = pmd_pkg::ST_CLEAR;
      default: st_nxt = pmd_pkg::ST_CLEAR;
    endcase
  end

  always_comb begin
    cmd  = '0;
    busy = 1'b1;
    case (st_r)
      pmd_pkg::ST_CLEAR: cmd.clear_step = 1'b1;
      pmd_pkg::ST_IDLE: begin
        busy       = 1'b0;
        cmd.accept = start;
      end
      pmd_pkg::ST_LD_READ: ;
      pmd_pkg::ST_LD_WR1: cmd.ld_wr1 = 1'b1;
      pmd_pkg::ST_LD_WR2: cmd.ld_wr2 = 1'b1;
      pmd_pkg::ST_INIT: begin
        cmd.prim_init   = 1'b1;
        cmd.clear_start = sts.n_one;
      end
      pmd_pkg::ST_SWEEP: cmd.scan_issue = 1'b1;
      pmd_pkg::ST_SWEEP_DRAIN: ;
      pmd_pkg::ST_ROUND_END: begin
        if (sts.found && !sts.rnd_last) cmd.next_round = 1'b1;
        else cmd.emit_start = 1'b1;
      end
      pmd_pkg::ST_EMIT: cmd.emit_issue = 1'b1;
      pmd_pkg::ST_EMIT_DRAIN: cmd.clear_start = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= pmd_pkg::ST_CLEAR;
      last_r <= 1'b0;
    end else begin
      st_r   <= st_nxt;
      last_r <= last_nxt;
    end
  end

endmodule

### hw/rtl/pmd_dp.sv
// ----------------------------------------------------------------------------
// pmd_dp
// Datapath: adjacency memory, key and link memory, vertex flags, scan
// counters, minimum search and the result register.
// ----------------------------------------------------------------------------
module pmd_dp #(
  parameter int MAX_VERTICES = pmd_pkg::MAX_VERTICES_DEF,
  parameter int WEIGHT_BITS  = pmd_pkg::WEIGHT_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  pmd_pkg::cmd_t                    cmd,
  output pmd_pkg::sts_t                    sts,
  input  logic [pmd_pkg::VERT_W-1:0]       in_edge_u,
  input  logic [pmd_pkg::VERT_W-1:0]       in_edge_v,
  input  logic signed [WEIGHT_BITS-1:0]    in_edge_weight,
  input  logic                             cfg_we,
  input  logic [pmd_pkg::CFG_W-1:0]        cfg_wdata,
  output logic                             out_valid,
  output logic [pmd_pkg::VERT_W-1:0]       out_tree_parent,
  output logic [pmd_pkg::VERT_W-1:0]       out_tree_child,
  output logic signed [WEIGHT_BITS-1:0]    out_tree_weight,
  output logic                             out_reached,
  output logic                             out_last_result
);

  localparam int VW     = $clog2(MAX_VERTICES);
  localparam int AW     = 2 * VW;
  localparam int EDEPTH = 1 << AW;
  localparam int NW     = $clog2(MAX_VERTICES + 1);
  localparam int CW     = (NW > pmd_pkg::CFG_W) ? NW : pmd_pkg::CFG_W;
  localparam int VN     = pmd_pkg::VERT_W;

  // memories
  logic [WEIGHT_BITS:0]          edge_mem [EDEPTH];
  logic signed [WEIGHT_BITS-1:0] key_mem  [MAX_VERTICES];
  logic [VW-1:0]                 link_mem [MAX_VERTICES];
  logic [WEIGHT_BITS:0]          edge_rd_r;
  logic signed [WEIGHT_BITS-1:0] key_rd_r;
  logic [VW-1:0]                 link_rd_r;

  // registers
  logic [CW-1:0]                 cfg_r, cfg_nxt;
  logic [VW-1:0]                 ld_u_r, ld_u_nxt;
  logic [VW-1:0]                 ld_v_r, ld_v_nxt;
  logic signed [WEIGHT_BITS-1:0] ld_w_r, ld_w_nxt;
  logic                          ld_ok_r, ld_ok_nxt;
  logic                          upd_r, upd_nxt;
  logic [VW-1:0]                 scan_r, scan_nxt;
  logic [VW-1:0]                 u_r, u_nxt;
  logic [VW-1:0]                 rnd_r, rnd_nxt;
  logic                          found_r, found_nxt;
  logic [VW-1:0]                 sel_r, sel_nxt;
  logic signed [WEIGHT_BITS-1:0] least_r, least_nxt;
  logic                          s1_valid_r, s1_valid_nxt;
  logic                          s1_emit_r, s1_emit_nxt;
  logic [VW-1:0]                 s1_v_r, s1_v_nxt;
  logic [AW-1:0]                 clr_r, clr_nxt;
  logic [MAX_VERTICES-1:0]       known_r, taken_r;
  logic                          out_valid_r;
  logic [VN-1:0]                 out_tree_parent_r, out_tree_child_r;
  logic signed [WEIGHT_BITS-1:0] out_tree_weight_r;
  logic                          out_reached_r, out_last_result_r;

  // combinational
  logic [VW-1:0]                 n_m1;
  logic [CW-1:0]                 n_act;
  logic                          upd_c;
  logic signed [WEIGHT_BITS-1:0] e_w;
  logic                          e_pres;
  logic                          kn, tk, relax, cand;
  logic signed [WEIGHT_BITS-1:0] key_new;
  logic                          e_we;
  logic [AW-1:0]                 e_waddr, e_raddr;
  logic [WEIGHT_BITS:0]          e_wdata;
  logic [VW:0]                   link_p1, child_p1;

  always_comb begin
    if (cfg_r == '0) n_m1 = '0;
    else if (cfg_r > CW'(MAX_VERTICES)) n_m1 = VW'(MAX_VERTICES - 1);
    else n_m1 = VW'(cfg_r - CW'(1));
    n_act = CW'(n_m1) + CW'(1);
  end

  assign e_pres  = edge_rd_r[WEIGHT_BITS];
  assign e_w     = edge_rd_r[WEIGHT_BITS-1:0];
  assign kn      = known_r[s1_v_r];
  assign tk      = taken_r[s1_v_r];
  assign upd_c   = ld_ok_r && (!e_pres || (ld_w_r < e_w));
  assign relax   = s1_valid_r && !s1_emit_r && e_pres && !tk && (!kn || (e_w < key_rd_r));
  assign key_new = relax ? e_w : key_rd_r;
  assign cand    = s1_valid_r && !s1_emit_r && !tk && (kn || relax) &&
                   (!found_r || (key_new < least_r));
  assign link_p1  = {1'b0, link_rd_r} + (VW+1)'(1);
  assign child_p1 = {1'b0, s1_v_r} + (VW+1)'(1);

  // edge memory port selection
  always_comb begin
    e_we    = 1'b0;
    e_waddr = clr_r;
    e_wdata = '0;
    e_raddr = cmd.scan_issue ? {u_r, scan_r} : {ld_u_r, ld_v_r};
    if (cmd.clear_step) begin
      e_we = 1'b1;
    end else if (cmd.ld_wr1) begin
      e_we    = upd_c;
      e_waddr = {ld_u_r, ld_v_r};
      e_wdata = {1'b1, ld_w_r};
    end else if (cmd.ld_wr2) begin
      e_we    = upd_r;
      e_waddr = {ld_v_r, ld_u_r};
      e_wdata = {1'b1, ld_w_r};
    end
  end

  always_comb begin
    cfg_nxt      = cfg_we ? CW'(cfg_wdata) : cfg_r;
    ld_u_nxt     = ld_u_r;
    ld_v_nxt     = ld_v_r;
    ld_w_nxt     = ld_w_r;
    ld_ok_nxt    = ld_ok_r;
    upd_nxt      = cmd.ld_wr1 ? upd_c : upd_r;
    scan_nxt     = scan_r;
    u_nxt        = u_r;
    rnd_nxt      = rnd_r;
    found_nxt    = found_r;
    sel_nxt      = sel_r;
    least_nxt    = least_r;
    s1_valid_nxt = cmd.scan_issue || cmd.emit_issue;
    s1_emit_nxt  = cmd.emit_issue;
    s1_v_nxt     = scan_r;
    clr_nxt      = clr_r;
    if (cmd.accept) begin
      ld_u_nxt  = VW'(in_edge_u - VN'(1));
      ld_v_nxt  = VW'(in_edge_v - VN'(1));
      ld_w_nxt  = in_edge_weight;
      ld_ok_nxt = (in_edge_u != '0) && (CW'(in_edge_u) <= n_act) &&
                  (in_edge_v != '0) && (CW'(in_edge_v) <= n_act);
    end
    if (cand) begin
      found_nxt = 1'b1;
      sel_nxt   = s1_v_r;
      least_nxt = key_new;
    end
    if (cmd.prim_init) begin
      u_nxt     = '0;
      rnd_nxt   = VW'(1);
      found_nxt = 1'b0;
      scan_nxt  = '0;
    end
    if (cmd.scan_issue || cmd.emit_issue) scan_nxt = scan_r + VW'(1);
    if (cmd.next_round) begin
      u_nxt     = sel_r;
      rnd_nxt   = rnd_r + VW'(1);
      found_nxt = 1'b0;
      scan_nxt  = '0;
    end
    if (cmd.emit_start) scan_nxt = VW'(1);
    if (cmd.clear_start) clr_nxt = '0;
    else if (cmd.clear_step) clr_nxt = clr_r + AW'(1);
  end

  always_comb begin
    sts.n_one     = (n_m1 == '0);
    sts.scan_last = (scan_r == n_m1);
    sts.found     = found_r;
    sts.rnd_last  = (rnd_r == n_m1);
    sts.clr_last  = (clr_r == '1);
  end

  always_ff @(posedge clk) begin
    if (e_we) edge_mem[e_waddr] <= e_wdata;
    edge_rd_r <= edge_mem[e_raddr];
  end

  always_ff @(posedge clk) begin
    if (relax) begin
      key_mem[s1_v_r]  <= e_w;
      link_mem[s1_v_r] <= u_r;
    end
    key_rd_r  <= key_mem[scan_r];
    link_rd_r <= link_mem[scan_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.clear_start) begin
      known_r <= '0;
      taken_r <= '0;
    end else begin
      if (cmd.prim_init) begin
        known_r[0] <= 1'b1;
        taken_r[0] <= 1'b1;
      end
      if (cmd.next_round) taken_r[sel_r] <= 1'b1;
      if (relax) known_r[s1_v_r] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r       <= CW'(MAX_VERTICES);
      found_r     <= 1'b0;
      s1_valid_r  <= 1'b0;
      s1_emit_r   <= 1'b0;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      cfg_r       <= cfg_nxt;
      found_r     <= found_nxt;
      s1_valid_r  <= s1_valid_nxt;
      s1_emit_r   <= s1_emit_nxt;
      clr_r       <= clr_nxt;
      out_valid_r <= s1_valid_r && s1_emit_r;
    end
  end

  always_ff @(posedge clk) begin
    ld_u_r            <= ld_u_nxt;
    ld_v_r            <= ld_v_nxt;
    ld_w_r            <= ld_w_nxt;
    ld_ok_r           <= ld_ok_nxt;
    upd_r             <= upd_nxt;
    scan_r            <= scan_nxt;
    u_r               <= u_nxt;
    rnd_r             <= rnd_nxt;
    sel_r             <= sel_nxt;
    least_r           <= least_nxt;
    s1_v_r            <= s1_v_nxt;
    out_tree_parent_r <= kn ? VN'(link_p1) : '0;
    out_tree_child_r  <= VN'(child_p1);
    out_tree_weight_r <= kn ? key_rd_r : '0;
    out_reached_r     <= kn;
    out_last_result_r <= (s1_v_r == n_m1);
  end

  assign out_valid       = out_valid_r;
  assign out_tree_parent = out_tree_parent_r;
  assign out_tree_child  = out_tree_child_r;
  assign out_tree_weight = out_tree_weight_r;
  assign out_reached     = out_reached_r;
  assign out_last_result = out_last_result_r;

  a_port_excl: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.clear_step, cmd.ld_wr1, cmd.ld_wr2, s1_valid_r}))
    else $error("edge memory port used by two sources");

  a_sel_untaken: assert property (@(posedge clk) disable iff (!rst_n)
    found_r |-> !taken_r[sel_r])
    else $error("selected vertex already taken");

  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_last_result_r |=> !out_valid_r)
    else $error("result after last item");

  a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.accept |-> !s1_valid_r && !out_valid_r)
    else $error("work in flight at accept");

endmodule

### hw/rtl/prim_mst_dense.sv
// ----------------------------------------------------------------------------
// prim_mst_dense
// Dense prim minimum spanning tree over a loaded edge list, rooted at vertex 1.
//
//   channel  ports                                        handshake
//   input    in_edge_u/v, in_edge_weight, in_last_edge    start && !busy
//   result   out_tree_*, out_reached, out_last_result     out_valid, one cycle
//   config   cfg_wdata                                    cfg_we
//
// an edge item holds busy through its read, compare-and-write and mirror write
// a last item with n > 1 then runs the prim sweeps, which read one adjacency
// entry per cycle, and the result emission
// the adjacency store is then cleared, all 4**ceil(log2(MAX_VERTICES)) entries,
// 1024 by default; the same pass runs after reset with busy high
// results cannot be held off; configuration is taken at any cycle
// ----------------------------------------------------------------------------
module prim_mst_dense #(
  parameter int MAX_VERTICES = pmd_pkg::MAX_VERTICES_DEF,
  parameter int WEIGHT_BITS  = pmd_pkg::WEIGHT_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [pmd_pkg::VERT_W-1:0]    in_edge_u,
  input  logic [pmd_pkg::VERT_W-1:0]    in_edge_v,
  input  logic signed [WEIGHT_BITS-1:0] in_edge_weight,
  input  logic                          in_last_edge,
  output logic                          out_valid,
  output logic [pmd_pkg::VERT_W-1:0]    out_tree_parent,
  output logic [pmd_pkg::VERT_W-1:0]    out_tree_child,
  output logic signed [WEIGHT_BITS-1:0] out_tree_weight,
  output logic                          out_reached,
  output logic                          out_last_result,
  input  logic                          cfg_we,
  input  logic [pmd_pkg::CFG_W-1:0]     cfg_wdata
);

  pmd_pkg::cmd_t cmd;
  pmd_pkg::sts_t sts;

  pmd_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .in_last_edge (in_last_edge),
    .sts          (sts),
    .busy         (busy),
    .cmd          (cmd)
  );

  pmd_dp #(
    .MAX_VERTICES (MAX_VERTICES),
    .WEIGHT_BITS  (WEIGHT_BITS)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .in_edge_u       (in_edge_u),
    .in_edge_v       (in_edge_v),
    .in_edge_weight  (in_edge_weight),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .out_valid       (out_valid),
    .out_tree_parent (out_tree_parent),
    .out_tree_child  (out_tree_child),
    .out_tree_weight (out_tree_weight),
    .out_reached     (out_reached),
    .out_last_result (out_last_result)
  );

endmodule
